/* hdl/ple_pkg.sv */
// Shared types and constants for the positional list engine.
// No dependencies; used by ple_cell and positional_list_engine_core.
package ple_pkg;

  localparam int POS_W = 8;   // position field width
  localparam int VAL_W = 32;  // value field width on the ports
  localparam int LEN_W = 7;   // length field width on the ports

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                     operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value_in;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_out;
    status_t                 status;
    logic [LEN_W-1:0]        length;
    logic                    is_empty;
  } out_t;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic             ins;   // open a gap at slot, shift later entries up
    logic             del;   // close the entry at slot, shift later down
    logic [POS_W-1:0] slot;  // 0-based target slot
  } ctrl_t;

endpackage

/* hdl/ple_cell.sv */
// One storage cell of the list chain: holds one element and trades it
// with its neighbors on insert/delete. Depends on ple_pkg.
module ple_cell #(
  parameter int INDEX      = 0,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  ple_pkg::ctrl_t        ctrl,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic [DATA_WIDTH-1:0] ins_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] rd_data
);
  import ple_pkg::*;

  localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  hit;

  assign hit = (ctrl.slot == IDX);

  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins) begin
      if (hit) begin
        data_nxt = ins_data;
      end else if (IDX > ctrl.slot) begin
        data_nxt = left_data;
      end
    end else if (ctrl.del) begin
      if (IDX >= ctrl.slot) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  // gated read tap, OR-combined at the top level
  assign rd_data = hit ? data_r : '0;

endmodule

/* hdl/positional_list_engine_core.sv */
// Top level of the positional list engine: command decode, length
// counter, result register and the chain of ple_cell storage cells.
// Depends on ple_pkg and ple_cell.
//
// Usage:
//  - Input channel: drive in_item and raise start; the command transfers
//    at the rising edge where start is high and busy is low. busy never
//    rises, so a command can transfer on every clock.
//  - Each command returns exactly one result on out_item, shown for one
//    cycle with out_strobe high, in the cycle after the command transfer
//    (throughput 1 command per cycle).
//  - Insert/delete shift every later element by one cell, all together;
//    each cell trades with its neighbor, so the chain of CAPACITY
//    cells sets the cost, not the cycle count.
//  - Read/delete data comes from a gated OR across the cell taps.
//  - The receiver cannot stall; a result not taken in its cycle is lost.
//  - Reset (rst_n low, synchronous) empties the list and drops any
//    pending result. Cell contents are left as they are: only cells below
//    the length are ever read, and those were all written after reset.
module positional_list_engine_core #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ple_pkg::in_t  in_item,
  output logic          out_strobe,
  output ple_pkg::out_t out_item
);
  import ple_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  // state
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_strobe_r;
  out_t             out_item_r, out_item_nxt;

  // decode
  logic             xfer;
  logic [POS_W:0]   pos_ext;
  logic [POS_W:0]   cnt_ext;
  logic             pos_zero;
  logic             ins_pos_ok, acc_pos_ok, full;
  ctrl_t            ctrl;
  status_t          status;
  logic             ret_data;

  // chain
  logic [DATA_WIDTH-1:0] ins_data;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_sel;
  logic [VAL_W-1:0]      rd_val;

  assign busy = 1'b0;
  assign xfer = start && !busy;

  assign pos_ext  = {1'b0, in_item.position};
  assign cnt_ext  = (POS_W+1)'(count_r);
  assign pos_zero = (in_item.position == '0);
  assign ins_pos_ok = !pos_zero && (pos_ext <= cnt_ext + (POS_W+1)'(1));
  assign acc_pos_ok = !pos_zero && (pos_ext <= cnt_ext);
  assign full       = (count_r == CAP_C);

  // store-width value, zero-extended when cells are wider than the port
  generate
    if (DATA_WIDTH <= VAL_W) begin : g_ins_narrow
      assign ins_data = in_item.value_in[DATA_WIDTH-1:0];
    end else begin : g_ins_wide
      assign ins_data = {{(DATA_WIDTH-VAL_W){1'b0}}, in_item.value_in};
    end
  endgenerate

  always_comb begin
    ctrl      = '0;
    ctrl.slot = in_item.position - POS_W'(1);
    status    = ST_OK;
    ret_data  = 1'b0;
    count_nxt = count_r;
    case (in_item.operation)
      OP_INSERT: begin
        if (!ins_pos_ok) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.ins  = xfer;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (!acc_pos_ok) begin
          status = ST_RANGE;
        end else begin
          ctrl.del  = xfer;
          ret_data  = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (!acc_pos_ok) begin
          status = ST_RANGE;
        end else begin
          ret_data = 1'b1;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
  end

  // cell chain: each cell sees its left and right neighbor
  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w, right_w;
      if (i == 0) begin : g_first
        assign left_w = ins_data;
      end else begin : g_mid_l
        assign left_w = cell_data[i-1];
      end
      if (i == CAPACITY-1) begin : g_last
        assign right_w = cell_data[i];
      end else begin : g_mid_r
        assign right_w = cell_data[i+1];
      end
      ple_cell #(
        .INDEX      (i),
        .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .left_data  (left_w),
        .right_data (right_w),
        .ins_data   (ins_data),
        .data       (cell_data[i]),
        .rd_data    (cell_rd[i])
      );
    end
  endgenerate

  // at most one cell tap is nonzero
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_sel = rd_sel | cell_rd[i];
    end
  end

  generate
    if (DATA_WIDTH >= VAL_W) begin : g_rd_wide
      assign rd_val = rd_sel[VAL_W-1:0];
    end else begin : g_rd_narrow
      assign rd_val = {{(VAL_W-DATA_WIDTH){rd_sel[DATA_WIDTH-1]}}, rd_sel};
    end
  endgenerate

  always_comb begin
    out_item_nxt.value_out = ret_data ? rd_val : '0;
    out_item_nxt.status    = status;
    // low bits of the count; wraps for counts of 128 and above
    out_item_nxt.length    = LEN_W'(count_nxt);
    out_item_nxt.is_empty  = (count_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= xfer;
      if (xfer) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for positional_list_engine_core: directed and random list
// commands, each checked against a shadow list kept in the bench.
// Depends on ple_pkg and the engine RTL.
module tb_top;
  import ple_pkg::*;

  localparam int CAP        = 64;    // list capacity of the instance
  localparam int DW         = 32;    // stored element width of the instance
  localparam int ITEMS      = 1850;  // no new phase starts once this many are queued
  localparam int IDLE_LIMIT = 500;   // cycles without any transfer before giving up
  localparam int SHOW_MAX   = 10;    // mismatches printed in full

  logic clk        = 1'b0;
  logic rst_n      = 1'b0;
  logic start      = 1'b0;
  logic busy;
  in_t  in_item    = '0;
  logic out_strobe;
  out_t out_item;

  positional_list_engine_core #(
    .CAPACITY  (CAP),
    .DATA_WIDTH(DW)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the list contents and length.
  logic [DW-1:0] shadow_store [CAP];
  int            shadow_len = 0;

  in_t  cmd_queue [$];     // commands waiting for their transfer
  out_t list_replies [$];  // predicted replies, oldest first

  // Generator side: length that the queued commands will leave behind,
  // used to aim positions at the interesting ranges and to end the fill and drain loops.
  int gen_len = 0;
  int issued  = 0;

  // Transfer count from the monitor; the driver keeps its own copy to see
  // when its current command has gone.
  int xfer_count = 0;
  int xfer_seen  = 0;
  int burst_left = 1;
  int gap_left   = 0;

  int idle_cycles = 0;
  int errors      = 0;
  int op_hits [4] = '{default: 0};
  int range_hits  = 0;
  int full_hits   = 0;
  int peak_len    = 0;

  // Applies one command to the shadow list and returns the reply the
  // engine must give for it.
  function automatic out_t apply_list_cmd(in_t cmd);
    out_t r;
    int   p;
    int   k;
    r = '0;
    p = int'(cmd.position);
    case (cmd.operation)
      OP_INSERT: begin
        // position is checked first, fullness only for a good position
        if (p < 1 || p > shadow_len + 1) begin
          r.status = ST_RANGE;
        end else if (shadow_len >= CAP) begin
          r.status = ST_FULL;
        end else begin
          for (k = shadow_len; k >= p; k--) shadow_store[k] = shadow_store[k-1];
          shadow_store[p-1] = cmd.value_in[DW-1:0];
          shadow_len++;
        end
      end
      OP_DELETE: begin
        if (p < 1 || p > shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          r.value_out = VAL_W'(signed'(shadow_store[p-1]));
          for (k = p; k < shadow_len; k++) shadow_store[k-1] = shadow_store[k];
          shadow_len--;
        end
      end
      OP_READ: begin
        if (p < 1 || p > shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          r.value_out = VAL_W'(signed'(shadow_store[p-1]));
        end
      end
      OP_CLEAR: begin
        shadow_len = 0;
      end
    endcase
    r.length   = LEN_W'(shadow_len);
    r.is_empty = (shadow_len == 0);
    return r;
  endfunction

  // Queues one command and tracks the length it will leave.
  task automatic queue_cmd(input op_t op, input int pos, input logic [VAL_W-1:0] val);
    in_t c;
    c.operation = op;
    c.position  = pos[POS_W-1:0];
    c.value_in  = val;
    cmd_queue.push_back(c);
    issued++;
    case (op)
      OP_INSERT: if (pos >= 1 && pos <= gen_len + 1 && gen_len < CAP) gen_len++;
      OP_DELETE: if (pos >= 1 && pos <= gen_len) gen_len--;
      OP_CLEAR:  gen_len = 0;
      default:   ;
    endcase
  endtask

  // Mostly a legal position from 1 to lim, with edges and bad ones mixed in.
  function automatic int pick_pos(input int lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return (lim < 1) ? 1 : $urandom_range(1, lim);
    if (r < 80) return ($urandom_range(0, 1) == 0) ? lim : 1;
    if (r < 90) return lim + 1;
    if (r < 95) return 0;
    return $urandom_range(0, 255);
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 19))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Hold the sender off until every queued command has its reply back.
  task automatic settle();
    while (cmd_queue.size() != 0 || list_replies.size() != 0) @(negedge clk);
  endtask

  // Driver: presents the head of cmd_queue at the falling edge, in bursts
  // of random length with random gaps. Long bursts with no gaps at all
  // come up now and then.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (xfer_count != xfer_seen) begin
        xfer_seen = xfer_count;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0
                     : $urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 3);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        start   <= 1'b1;
        in_item <= cmd_queue[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: at each rising edge, predicts the reply of a command transfer
  // and checks any reply on the result port against the oldest prediction.
  // The prediction is queued before the check, so order within the edge
  // does not matter.
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (start && !busy) begin
        want = apply_list_cmd(in_item);
        list_replies.push_back(want);
        void'(cmd_queue.pop_front());
        xfer_count++;
        op_hits[in_item.operation]++;
        if (want.status == ST_RANGE) range_hits++;
        if (want.status == ST_FULL) full_hits++;
        if (shadow_len > peak_len) peak_len = shadow_len;
      end

      if (out_strobe) begin
        if (list_replies.size() == 0) begin
          errors++;
          if (errors <= SHOW_MAX)
            $display("[%0t] reply with no command outstanding: val=%0d st=%0d len=%0d",
                     $realtime, out_item.value_out, out_item.status, out_item.length);
        end else begin
          want = list_replies.pop_front();
          if (out_item.value_out !== want.value_out || out_item.status !== want.status ||
              out_item.length !== want.length || out_item.is_empty !== want.is_empty) begin
            errors++;
            if (errors <= SHOW_MAX)
              $display({"[%0t] reply mismatch: want val=%0d st=%0d len=%0d empty=%0b,",
                        " got val=%0d st=%0d len=%0d empty=%0b"},
                       $realtime, want.value_out, want.status, want.length, want.is_empty,
                       out_item.value_out, out_item.status, out_item.length,
                       out_item.is_empty);
          end
        end
      end

      // watchdog: a run that stops moving is a failure
      if ((start && !busy) || out_strobe) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] no transfer for %0d cycles, %0d commands and %0d replies pending",
                 $realtime, IDLE_LIMIT, cmd_queue.size(), list_replies.size());
        $display("FAIL positional_list_engine_core");
        $finish;
      end
    end
  end

  initial begin
    int mix;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, bad positions, front/middle/back insert and
    // delete, field extremes, clear on empty and on a filled list.
    queue_cmd(OP_READ,   1,   32'h0);
    queue_cmd(OP_DELETE, 1,   32'h0);
    queue_cmd(OP_CLEAR,  0,   32'h0);
    queue_cmd(OP_INSERT, 0,   32'h1234_5678);
    queue_cmd(OP_INSERT, 2,   32'h1234_5678);
    queue_cmd(OP_INSERT, 1,   32'h7FFF_FFFF);
    queue_cmd(OP_INSERT, 1,   32'h8000_0000);
    queue_cmd(OP_INSERT, 3,   32'hFFFF_FFFF);
    queue_cmd(OP_INSERT, 2,   32'h0);
    queue_cmd(OP_READ,   0,   32'hFFFF_FFFF);
    queue_cmd(OP_READ,   4,   32'h0);
    queue_cmd(OP_READ,   5,   32'h0);
    queue_cmd(OP_READ,   255, 32'h0);
    queue_cmd(OP_DELETE, 255, 32'h0);
    queue_cmd(OP_DELETE, 2,   32'h0);
    queue_cmd(OP_DELETE, 3,   32'h0);
    queue_cmd(OP_DELETE, 1,   32'h0);
    queue_cmd(OP_INSERT, 255, 32'h5555_AAAA);
    queue_cmd(OP_INSERT, 2,   32'hAAAA_5555);
    queue_cmd(OP_CLEAR,  255, 32'hFFFF_FFFF);
    queue_cmd(OP_READ,   1,   32'h0);
    settle();

    // Random phases: fill to capacity, poke the full list, drain it, then
    // mixed traffic. The sender waits for all replies after each round.
    while (issued < ITEMS) begin
      queue_cmd(OP_CLEAR, $urandom_range(0, 255), rand_value());
      while (gen_len < CAP) queue_cmd(OP_INSERT, $urandom_range(1, gen_len + 1), rand_value());
      // good positions now hit the full check, bad ones stay range errors
      queue_cmd(OP_INSERT, 1, rand_value());
      queue_cmd(OP_INSERT, CAP + 1, rand_value());
      queue_cmd(OP_INSERT, $urandom_range(1, CAP), rand_value());
      queue_cmd(OP_INSERT, CAP + 2, rand_value());
      queue_cmd(OP_READ, CAP, rand_value());
      queue_cmd(OP_READ, CAP + 1, rand_value());
      while (gen_len > 0) begin
        if ($urandom_range(0, 3) == 0) queue_cmd(OP_READ, pick_pos(gen_len), rand_value());
        queue_cmd(OP_DELETE, $urandom_range(1, gen_len), rand_value());
      end
      queue_cmd(OP_DELETE, 1, rand_value());

      // insert-heavy mix keeps the list near full much of the time
      repeat (310) begin
        mix = $urandom_range(0, 99);
        if (mix < 3)       queue_cmd(OP_CLEAR, $urandom_range(0, 255), rand_value());
        else if (mix < 48) queue_cmd(OP_INSERT, pick_pos(gen_len + 1), rand_value());
        else if (mix < 73) queue_cmd(OP_DELETE, pick_pos(gen_len), rand_value());
        else               queue_cmd(OP_READ, pick_pos(gen_len), rand_value());
      end
      settle();
    end

    // let the last reply land and catch any stray ones
    repeat (5) @(negedge clk);

    $display("Covered %0d commands: %0d insert, %0d delete, %0d read, %0d clear",
             xfer_count, op_hits[OP_INSERT], op_hits[OP_DELETE], op_hits[OP_READ],
             op_hits[OP_CLEAR]);
    $display("%0d out-of-range and %0d full rejections, peak length %0d, %0d mismatches",
             range_hits, full_hits, peak_len, errors);
    if (errors == 0) begin
      $display("PASS positional_list_engine_core");
    end else begin
      $display("FAIL positional_list_engine_core");
    end
    $finish;
  end

endmodule
